[rtl/cpps_pkg.sv]
// ----------------------------------------------------------------------------
// cpps_pkg
// Shared types, codes and constants of the convex polygon plane splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package cpps_pkg;

  localparam int MAX_VERTS = 16;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int T_BITS    = 24;
  localparam int CNT_W     = 5;

  // 0.05 in Q16.16
  localparam logic signed [31:0] DIST_THR = 32'sd3277;

  typedef enum logic [CFG_AW-1:0] {
    CFG_PLANE_X,
    CFG_PLANE_Y,
    CFG_PLANE_Z,
    CFG_NORMAL_X,
    CFG_NORMAL_Y,
    CFG_NORMAL_Z,
    CFG_SPL_DEPTH,
    CFG_SPL_ORDER
  } cfg_idx_e;

  typedef enum logic [2:0] {
    VD_FRONT,
    VD_BACK,
    VD_COP_FRONT,
    VD_COP_BACK,
    VD_SPLIT,
    VD_OVERFLOW
  } verdict_e;

  typedef enum logic [2:0] {
    OUT_OVF,
    OUT_WHOLE,
    OUT_START,
    OUT_VERT,
    OUT_END
  } out_kind_e;

  typedef enum logic [1:0] {
    RD_WALK,
    RD_A,
    RD_B
  } rd_sel_e;

  typedef logic [2:0][31:0] vec_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic [15:0]        poly_depth;
    logic [15:0]        poly_order;
    logic               final_vertex;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         verdict;
    logic               side;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               fragment_end;
    logic               run_end;
  } out_word_t;

  typedef struct packed {
    logic      take;
    logic      mac;
    logic [1:0] comp;
    logic      dist_wr;
    logic      clear;
    logic      scan_init;
    logic      scan_step;
    logic      walk_init;
    logic      walk_next;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      isel;
    logic      lat_a;
    logic      lat_b;
    logic      div_init;
    logic      div_step;
    logic      imul;
    logic      frag_back;
    logic      out_load;
    out_kind_e kind;
  } dp_cmd_t;

  typedef struct packed {
    logic take_stored;
    logic take_final;
    logic final_seen;
    logic ovf;
    logic whole;
    logic scan_last;
    logic walk_nlast;
    logic walk_stop;
    logic end_needed;
    logic out_free;
    logic frag;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/cpps_vtx_if.sv]
// ----------------------------------------------------------------------------
// cpps_vtx_if
// Vertex input channel: valid, ready and one vertex word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpps_vtx_if;
  import cpps_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/cpps_res_if.sv]
// ----------------------------------------------------------------------------
// cpps_res_if
// Result channel: valid, ready and one tagged output vertex word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpps_res_if;
  import cpps_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/cpps_ram.sv]
// ----------------------------------------------------------------------------
// cpps_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpps_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            we_i,
  input  wire logic [$clog2(Depth)-1:0]        waddr_i,
  input  wire logic [Width-1:0]                wdata_i,
  input  wire logic                            re_i,
  input  wire logic [$clog2(Depth)-1:0]        raddr_i,
  output logic      [Width-1:0]                rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/cpps_dp.sv]
// ----------------------------------------------------------------------------
// cpps_dp
// Datapath: config registers, vertex and distance stores, distance MAC,
// side masks, split search, t divider, interpolation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpps_dp #(
  parameter int MaxVerts = cpps_pkg::MAX_VERTS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [cpps_pkg::CFG_AW-1:0]       cfg_idx_i,
  input  wire logic [cpps_pkg::CFG_DW-1:0]       cfg_wdata_i,
  input  wire cpps_pkg::in_word_t                in_data_i,
  input  wire cpps_pkg::dp_cmd_t                 cmd_i,
  output cpps_pkg::dp_stat_t                     stat_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output cpps_pkg::out_word_t                    out_data_o
);
  import cpps_pkg::*;

  localparam int IW = $clog2(MaxVerts);
  localparam int CW = $clog2(MaxVerts + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MaxVerts);

  logic signed [31:0] plane_q  [3];
  logic signed [17:0] normal_q [3];
  logic [15:0]        spl_depth_q, spl_order_q;

  logic [CW-1:0]       count_q;
  logic                ovf_q, final_q;
  logic [15:0]         held_depth_q, held_order_q;
  logic [MaxVerts-1:0] pos_mask_q, neg_mask_q;

  logic signed [31:0] vin_q [3];
  logic signed [50:0] prod_q;
  logic signed [52:0] acc_q;

  logic [IW-1:0] scan_q, pos_first_q, neg_first_q, pos_run_q, neg_run_q;
  logic          pos_found_q, neg_found_q;
  logic [IW-1:0] walk_q;
  logic          frag_q;

  vec_t               va_q, vb_q, pos_pt_q, neg_pt_q;
  logic signed [31:0] da_q, db_q;
  logic [33:0]        rem_q, dd_q;
  logic [24:0]        numlo_q, t_q;
  logic signed [58:0] iprod_q;

  logic      out_valid_q;
  out_word_t out_q;

  // stores
  logic [IW-1:0] idx_w, rd_addr;
  vec_t          vin_vec, vram_rdata;
  logic [31:0]   dram_rdata;
  logic signed [31:0] dstore;
  logic          stored_now;

  assign idx_w      = count_q[IW-1:0];
  assign stored_now = count_q < MaxCnt;
  assign vin_vec    = {in_data_i.vertex_z, in_data_i.vertex_y, in_data_i.vertex_x};

  cpps_ram #(.Width(96), .Depth(MaxVerts)) u_vram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take && stored_now),
    .waddr_i (idx_w),
    .wdata_i (vin_vec),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (vram_rdata)
  );

  cpps_ram #(.Width(32), .Depth(MaxVerts)) u_dram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.dist_wr),
    .waddr_i (idx_w),
    .wdata_i (dstore),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (dram_rdata)
  );

  // distance
  logic signed [31:0] vsel, psel;
  logic signed [17:0] nsel;
  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic signed [52:0] dsum, dsh;
  logic signed [31:0] dsat;
  logic               dpos, dneg;

  always_comb begin
    case (cmd_i.comp)
      2'd0:    begin vsel = vin_q[0]; psel = plane_q[0]; nsel = normal_q[0]; end
      2'd1:    begin vsel = vin_q[1]; psel = plane_q[1]; nsel = normal_q[1]; end
      default: begin vsel = vin_q[2]; psel = plane_q[2]; nsel = normal_q[2]; end
    endcase
    diff = $signed({vsel[31], vsel}) - $signed({psel[31], psel});
    prod = diff * nsel;
    dsum = acc_q + 53'sd32768;
    dsh  = dsum >>> 16;
    if (!dsh[52] && (|dsh[51:31])) begin
      dsat = 32'sh7FFFFFFF;
    end else if (dsh[52] && !(&dsh[51:31])) begin
      dsat = 32'sh80000000;
    end else begin
      dsat = dsh[31:0];
    end
    dpos   = dsat > DIST_THR;
    dneg   = dsat < -DIST_THR;
    dstore = (dpos || dneg) ? dsat : 32'sd0;
  end

  // split search
  logic [IW-1:0] n_last, fb, bb, a_idx, b_idx, begin_idx, stop_idx, walk_nx;
  logic [IW-1:0] scan_pv;
  logic          sp, sn, spp, snp;

  function automatic logic [IW-1:0] prev_i(logic [IW-1:0] x, logic [IW-1:0] last);
    return (x == '0) ? last : x - IW'(1);
  endfunction

  always_comb begin
    n_last  = IW'(count_q - CW'(1));
    scan_pv = scan_q - IW'(1);
    sp      = pos_mask_q[scan_q];
    sn      = neg_mask_q[scan_q];
    spp     = (scan_q != '0) && pos_mask_q[scan_pv];
    snp     = (scan_q != '0) && neg_mask_q[scan_pv];
    fb = (pos_mask_q[0] && pos_mask_q[n_last]) ? pos_run_q : pos_first_q;
    bb = (neg_mask_q[0] && neg_mask_q[n_last]) ? neg_run_q : neg_first_q;
    b_idx     = cmd_i.isel ? bb : fb;
    a_idx     = prev_i(b_idx, n_last);
    begin_idx = frag_q ? bb : fb;
    stop_idx  = frag_q ? fb : bb;
    walk_nx   = (walk_q == n_last) ? '0 : walk_q + IW'(1);
    unique case (cmd_i.rd_sel)
      RD_A:    rd_addr = a_idx;
      RD_B:    rd_addr = b_idx;
      default: rd_addr = walk_q;
    endcase
  end

  // divider and interpolation
  logic [31:0] ma, mb;
  logic [32:0] den;
  logic [57:0] num;
  logic [34:0] r2;
  logic [1:0]  icomp;
  logic [1:0]  scomp;
  logic signed [32:0] delta;
  logic signed [58:0] iprod, ir, ioff;
  logic [31:0] ires, abase;

  always_comb begin
    ma  = da_q[31] ? (~da_q + 32'd1) : da_q;
    mb  = db_q[31] ? (~db_q + 32'd1) : db_q;
    den = {1'b0, ma} + {1'b0, mb};
    num = {1'b0, ma, 25'd0} + {25'd0, den};
    r2  = {rem_q, numlo_q[24]};
    icomp = cmd_i.comp;
    scomp = icomp - 2'd1;
    case (icomp)
      2'd0:    delta = $signed({vb_q[0][31], vb_q[0]}) - $signed({va_q[0][31], va_q[0]});
      2'd1:    delta = $signed({vb_q[1][31], vb_q[1]}) - $signed({va_q[1][31], va_q[1]});
      default: delta = $signed({vb_q[2][31], vb_q[2]}) - $signed({va_q[2][31], va_q[2]});
    endcase
    iprod = delta * $signed({1'b0, t_q});
    ir    = iprod_q + 59'sd8388608;
    ioff  = ir >>> T_BITS;
    case (scomp)
      2'd0:    abase = va_q[0];
      2'd1:    abase = va_q[1];
      default: abase = va_q[2];
    endcase
    ires = abase + ioff[31:0];
  end

  // output word
  vec_t      start_pt, end_pt;
  logic      end_eq, pos_none, neg_none, later;
  logic [2:0] whole_vd;
  out_word_t out_d;

  always_comb begin
    start_pt = frag_q ? neg_pt_q : pos_pt_q;
    end_pt   = frag_q ? pos_pt_q : neg_pt_q;
    end_eq   = vram_rdata == end_pt;
    pos_none = pos_mask_q == '0;
    neg_none = neg_mask_q == '0;
    later    = (held_depth_q > spl_depth_q) ||
               ((held_depth_q == spl_depth_q) && (held_order_q >= spl_order_q));
    if (pos_none && neg_none) begin
      whole_vd = later ? VD_COP_FRONT : VD_COP_BACK;
    end else begin
      whole_vd = neg_none ? VD_FRONT : VD_BACK;
    end
    out_d = '0;
    unique case (cmd_i.kind)
      OUT_OVF: begin
        out_d.verdict      = VD_OVERFLOW;
        out_d.fragment_end = 1'b1;
        out_d.run_end      = 1'b1;
      end
      OUT_WHOLE: begin
        out_d.verdict      = whole_vd;
        out_d.side         = (whole_vd == VD_BACK) || (whole_vd == VD_COP_BACK);
        out_d.out_x        = vram_rdata[0];
        out_d.out_y        = vram_rdata[1];
        out_d.out_z        = vram_rdata[2];
        out_d.fragment_end = walk_q == n_last;
        out_d.run_end      = walk_q == n_last;
      end
      OUT_START: begin
        out_d.verdict = VD_SPLIT;
        out_d.side    = frag_q;
        out_d.out_x   = start_pt[0];
        out_d.out_y   = start_pt[1];
        out_d.out_z   = start_pt[2];
      end
      OUT_VERT: begin
        out_d.verdict      = VD_SPLIT;
        out_d.side         = frag_q;
        out_d.out_x        = vram_rdata[0];
        out_d.out_y        = vram_rdata[1];
        out_d.out_z        = vram_rdata[2];
        out_d.fragment_end = (walk_nx == stop_idx) && end_eq;
        out_d.run_end      = (walk_nx == stop_idx) && end_eq && frag_q;
      end
      OUT_END: begin
        out_d.verdict      = VD_SPLIT;
        out_d.side         = frag_q;
        out_d.out_x        = end_pt[0];
        out_d.out_y        = end_pt[1];
        out_d.out_z        = end_pt[2];
        out_d.fragment_end = 1'b1;
        out_d.run_end      = frag_q;
      end
      default: out_d = '0;
    endcase
  end

  always_comb begin
    stat_o.take_stored = stored_now;
    stat_o.take_final  = in_data_i.final_vertex;
    stat_o.final_seen  = final_q;
    stat_o.ovf         = ovf_q;
    stat_o.whole       = pos_none || neg_none;
    stat_o.scan_last   = scan_q == n_last;
    stat_o.walk_nlast  = walk_q == n_last;
    stat_o.walk_stop   = walk_nx == stop_idx;
    stat_o.end_needed  = !end_eq;
    stat_o.out_free    = !out_valid_q || out_ready_i;
    stat_o.frag        = frag_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q[0]   <= '0;
      plane_q[1]   <= '0;
      plane_q[2]   <= '0;
      normal_q[0]  <= '0;
      normal_q[1]  <= '0;
      normal_q[2]  <= 18'sd65536;
      spl_depth_q  <= '0;
      spl_order_q  <= '0;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      final_q      <= 1'b0;
      held_depth_q <= '0;
      held_order_q <= '0;
      pos_mask_q   <= '0;
      neg_mask_q   <= '0;
      out_valid_q  <= 1'b0;
      frag_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_PLANE_X:   plane_q[0]  <= cfg_wdata_i;
          CFG_PLANE_Y:   plane_q[1]  <= cfg_wdata_i;
          CFG_PLANE_Z:   plane_q[2]  <= cfg_wdata_i;
          CFG_NORMAL_X:  normal_q[0] <= cfg_wdata_i[17:0];
          CFG_NORMAL_Y:  normal_q[1] <= cfg_wdata_i[17:0];
          CFG_NORMAL_Z:  normal_q[2] <= cfg_wdata_i[17:0];
          CFG_SPL_DEPTH: spl_depth_q <= cfg_wdata_i[15:0];
          CFG_SPL_ORDER: spl_order_q <= cfg_wdata_i[15:0];
          default:       spl_order_q <= spl_order_q;
        endcase
      end
      if (cmd_i.take) begin
        final_q <= in_data_i.final_vertex;
        if ((count_q == '0) && !ovf_q) begin
          held_depth_q <= in_data_i.poly_depth;
          held_order_q <= in_data_i.poly_order;
        end
        if (!stored_now) begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.dist_wr) begin
        count_q <= count_q + CW'(1);
        if (dpos) pos_mask_q[idx_w] <= 1'b1;
        if (dneg) neg_mask_q[idx_w] <= 1'b1;
      end
      if (cmd_i.scan_init) begin
        frag_q <= 1'b0;
      end
      if (cmd_i.frag_back) begin
        frag_q <= 1'b1;
      end
      if (cmd_i.clear) begin
        count_q    <= '0;
        ovf_q      <= 1'b0;
        pos_mask_q <= '0;
        neg_mask_q <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      pos_found_q <= 1'b0;
      neg_found_q <= 1'b0;
      pos_first_q <= '0;
      neg_first_q <= '0;
      pos_run_q   <= '0;
      neg_run_q   <= '0;
      walk_q      <= '0;
    end else begin
      if (cmd_i.scan_init) begin
        scan_q      <= '0;
        pos_found_q <= 1'b0;
        neg_found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + IW'(1);
        if (sp && !pos_found_q) begin
          pos_first_q <= scan_q;
          pos_found_q <= 1'b1;
        end
        if (sn && !neg_found_q) begin
          neg_first_q <= scan_q;
          neg_found_q <= 1'b1;
        end
        if (sp && !spp) pos_run_q <= scan_q;
        if (sn && !snp) neg_run_q <= scan_q;
      end
      if (cmd_i.walk_init) begin
        walk_q <= (pos_none || neg_none) ? '0 : begin_idx;
      end else if (cmd_i.walk_next) begin
        walk_q <= walk_nx;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      vin_q[0] <= in_data_i.vertex_x;
      vin_q[1] <= in_data_i.vertex_y;
      vin_q[2] <= in_data_i.vertex_z;
    end
    if (cmd_i.mac) begin
      if (cmd_i.comp != 2'd3) prod_q <= prod;
      if (cmd_i.comp == 2'd0) begin
        acc_q <= '0;
      end else begin
        acc_q <= acc_q + {{2{prod_q[50]}}, prod_q};
      end
    end
    if (cmd_i.lat_a) begin
      va_q <= vram_rdata;
      da_q <= dram_rdata;
    end
    if (cmd_i.lat_b) begin
      vb_q <= vram_rdata;
      db_q <= dram_rdata;
    end
    if (cmd_i.div_init) begin
      rem_q   <= {1'b0, num[57:25]};
      numlo_q <= num[24:0];
      dd_q    <= {den, 1'b0};
      t_q     <= '0;
    end else if (cmd_i.div_step) begin
      numlo_q <= {numlo_q[23:0], 1'b0};
      if (r2 >= {1'b0, dd_q}) begin
        rem_q <= 34'(r2 - {1'b0, dd_q});
        t_q   <= {t_q[23:0], 1'b1};
      end else begin
        rem_q <= r2[33:0];
        t_q   <= {t_q[23:0], 1'b0};
      end
    end
    if (cmd_i.imul) begin
      if (icomp != 2'd3) iprod_q <= iprod;
      if (icomp != 2'd0) begin
        if (cmd_i.isel) neg_pt_q[scomp] <= ires;
        else            pos_pt_q[scomp] <= ires;
      end
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

[rtl/cpps_ctrl.sv]
// ----------------------------------------------------------------------------
// cpps_ctrl
// Sequencer: vertex intake, classification, split search, t division,
// interpolation and emission of the result words.
// ----------------------------------------------------------------------------
`default_nettype none

module cpps_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire cpps_pkg::dp_stat_t   stat_i,
  output cpps_pkg::dp_cmd_t         cmd_o
);
  import cpps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_MAC, S_DIST, S_FINAL, S_OVF_OUT, S_WRD, S_WLD, S_SCAN,
    S_IRA, S_IRB, S_ILAT, S_DIV, S_IMUL, S_START, S_FRD, S_FLD, S_END
  } state_e;

  localparam logic [CNT_W-1:0] DivLast = CNT_W'(T_BITS + 1);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              isel_q, isel_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    isel_d  = isel_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_WALK;
    cmd_o.kind   = OUT_OVF;
    cmd_o.isel   = isel_q;
    cmd_o.comp   = cnt_q[1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          cnt_d      = '0;
          if (stat_i.take_stored) state_d = S_MAC;
          else if (stat_i.take_final) state_d = S_FINAL;
        end
      end
      S_MAC: begin
        cmd_o.mac = 1'b1;
        cnt_d     = cnt_q + CNT_W'(1);
        if (cnt_q[1:0] == 2'd3) state_d = S_DIST;
      end
      S_DIST: begin
        cmd_o.dist_wr = 1'b1;
        state_d = stat_i.final_seen ? S_FINAL : S_IDLE;
      end
      S_FINAL: begin
        if (stat_i.ovf) begin
          state_d = S_OVF_OUT;
        end else if (stat_i.whole) begin
          cmd_o.walk_init = 1'b1;
          state_d = S_WRD;
        end else begin
          cmd_o.scan_init = 1'b1;
          isel_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_OVF_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.kind     = OUT_OVF;
          cmd_o.clear    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_WRD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_WLD;
      end
      S_WLD: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.kind     = OUT_WHOLE;
          if (stat_i.walk_nlast) begin
            cmd_o.clear = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.walk_next = 1'b1;
            state_d = S_WRD;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = S_IRA;
      end
      S_IRA: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_A;
        state_d = S_IRB;
      end
      S_IRB: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_B;
        cmd_o.lat_a  = 1'b1;
        state_d = S_ILAT;
      end
      S_ILAT: begin
        cmd_o.lat_b = 1'b1;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (cnt_q == '0) cmd_o.div_init = 1'b1;
        else             cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == DivLast) begin
          cnt_d   = '0;
          state_d = S_IMUL;
        end
      end
      S_IMUL: begin
        cmd_o.imul = 1'b1;
        cnt_d      = cnt_q + CNT_W'(1);
        if (cnt_q[1:0] == 2'd3) begin
          if (!isel_q) begin
            isel_d  = 1'b1;
            state_d = S_IRA;
          end else begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        if (stat_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.kind      = OUT_START;
          cmd_o.walk_init = 1'b1;
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_FLD;
      end
      S_FLD: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.kind     = OUT_VERT;
          if (!stat_i.walk_stop) begin
            cmd_o.walk_next = 1'b1;
            state_d = S_FRD;
          end else if (stat_i.end_needed) begin
            state_d = S_END;
          end else if (!stat_i.frag) begin
            cmd_o.frag_back = 1'b1;
            state_d = S_START;
          end else begin
            cmd_o.clear = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_END: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.kind     = OUT_END;
          if (!stat_i.frag) begin
            cmd_o.frag_back = 1'b1;
            state_d = S_START;
          end else begin
            cmd_o.clear = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      isel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      isel_q  <= isel_d;
    end
  end

endmodule

`default_nettype wire

[rtl/convex_polygon_plane_split.sv]
// ----------------------------------------------------------------------------
// convex_polygon_plane_split
// Splits a convex polygon, loaded one vertex word at a time, against a
// configured plane and emits the tagged vertices of the result.
//
//   channel   dir  handshake     word
//   vtx_i     in   valid/ready   vertex x,y,z, depth, order, final flag
//   res_o     out  valid/ready   verdict, side, x,y,z, fragment/run end
//   cfg       in   write enable  register index, 32-bit data
//
// A stored vertex is accepted, takes four multiply-accumulate steps and is
// stored; a dropped vertex is only accepted. The final vertex is followed by
// classification, then one overflow word, or a read and a load per word of
// a whole polygon; a split adds a scan, two bit-serial t divisions and
// interpolations, then a load per crossing word and a read and a load per
// stored vertex. The stores need no clearing pass after reset. The output
// register lets a new vertex be taken while the sink stalls the last word.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_polygon_plane_split #(
  parameter int MaxVerts = cpps_pkg::MAX_VERTS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cpps_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  wire logic [cpps_pkg::CFG_DW-1:0]   cfg_wdata_i,
  cpps_vtx_if.sink                           vtx_i,
  cpps_res_if.source                         res_o
);
  import cpps_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign vtx_i.ready = in_ready;

  cpps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vtx_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cpps_dp #(.MaxVerts(MaxVerts)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (vtx_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (res_o.data)
  );

endmodule

`default_nettype wire
